FILE: design/pks_pkg.sv
package pks_pkg;

   localparam int RATE_W     = 18;
   localparam int NLEN_W     = 24;
   localparam int DSTEP_W    = 32;
   localparam int TSIZE_W    = 16;
   localparam int TIDX_W     = 15;
   localparam int FREQ_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int FRAC_W     = 10;
   localparam int DIV_W      = RATE_W + FRAC_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int PROD_W     = NLEN_W + DSTEP_W;

   localparam logic [FREQ_W-1:0]  FREQ_LOW   = 24'd8397;
   localparam logic [FREQ_W-1:0]  FREQ_HIGH  = 24'd12845209;
   localparam logic [FREQ_W-1:0]  FREQ_START = 24'd450560;

   localparam logic [RATE_W-1:0]  RATE_RST  = 18'd48000;
   localparam logic [NLEN_W-1:0]  NLEN_RST  = 24'd48000;
   localparam logic [DSTEP_W-1:0] DSTEP_RST = 32'd89478;
   localparam logic [TSIZE_W-1:0] TSIZE_RST = 16'd23415;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_RATE = 2'd0,
      CSR_NOTE_LENGTH = 2'd1,
      CSR_DECAY_STEP  = 2'd2,
      CSR_TABLE_SIZE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: design/pks_if.sv
interface pks_req_if #(parameter int SW = 24);
   import pks_pkg::*;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [TIDX_W-1:0]   table_index;
   logic signed [SW-1:0] table_value;
   logic                note_start;
   logic signed [SW-1:0] mix_in;
   logic                freq_valid;
   logic [FREQ_W-1:0]   freq_value;
   modport source (output valid, req_type, table_index, table_value, note_start, mix_in,
                   freq_valid, freq_value, input ready);
   modport sink (input valid, req_type, table_index, table_value, note_start, mix_in,
                 freq_valid, freq_value, output ready);
endinterface

interface pks_rsp_if #(parameter int SW = 24);
   logic                 valid;
   logic                 ready;
   logic signed [SW-1:0] out_sample;
   logic                 in_note;
   modport source (output valid, out_sample, in_note, input ready);
   modport sink (input valid, out_sample, in_note, output ready);
endinterface

interface pks_csr_if;
   import pks_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: design/pks_ram.sv
module pks_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: design/pks_div.sv
module pks_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pks_pkg::DIV_W-1:0]         dividend,
   input  logic [pks_pkg::FREQ_W-1:0]        divisor,
   output pks_pkg::div_status_type           status,
   output logic [pks_pkg::DIV_W-1:0]         quotient
);
   import pks_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FREQ_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [FREQ_W-1:0]    dvsr_ff, dvsr_in;
   logic [FREQ_W+1:0]    trial;
   logic                 neg;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {1'b0, rem_ff, quo_ff[DIV_W-1]} - {2'b00, dvsr_ff};
      neg     = trial[FREQ_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         rem_in = neg ? {rem_ff[FREQ_W-2:0], quo_ff[DIV_W-1]} : trial[FREQ_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ~neg};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
endmodule

FILE: design/plucked_string_synth_top.sv
// load transfer: the noise entry is written as it is accepted; the block stays idle
// sample transfer inside a period: check, read, two multiply states, then output register
// sample transfer at a period start: adds the 28-step divider and the filter sweep over
//   the work memory at one entry per cycle
// synchronous reset clears control, loads CSR defaults; tables undefined until written
module plucked_string_synth_top #(
   parameter int TABLE_DEPTH = 32768,
   parameter int SAMPLE_BITS = 24
) (
   input logic    clock,
   input logic    reset,
   pks_req_if.sink   req_chan,
   pks_rsp_if.source rsp_chan,
   pks_csr_if.sink   csr_chan
);
   import pks_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;
   localparam int SW = SAMPLE_BITS;
   localparam int MW = SW + 33;
   localparam logic signed [MW-1:0] RND_HALF = MW'(1) << 31;
   localparam logic signed [SW:0]   SAT_MAX  = (SW+1)'((1 << (SW - 1)) - 1);
   localparam logic signed [SW:0]   SAT_MIN  = -SAT_MAX - 1;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CHECK = 9'b000000010,
      ST_DIV   = 9'b000000100,
      ST_PRE   = 9'b000001000,
      ST_SWEEP = 9'b000010000,
      ST_RD    = 9'b000100000,
      ST_MUL1  = 9'b001000000,
      ST_MUL2  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [RATE_W-1:0]    sample_rate_ff, sample_rate_in;
   logic [NLEN_W-1:0]    note_length_ff, note_length_in;
   logic [DSTEP_W-1:0]   decay_step_ff, decay_step_in;
   logic [TSIZE_W-1:0]   table_size_ff, table_size_in;
   logic [NLEN_W-1:0]    pos_ff, pos_in;
   logic [CW-1:0]        pidx_ff, pidx_in;
   logic [CW-1:0]        psamp_ff, psamp_in;
   logic [FREQ_W-1:0]    hf_ff, hf_in;
   logic                 first_ff, first_in;
   logic                 lat_ff, lat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] mix_ff, mix_in;
   logic [FREQ_W-1:0]    fv_ff, fv_in;
   logic                 fvalid_ff, fvalid_in;
   logic [CW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic                 lat_pre_ff, lat_pre_in;
   logic signed [SW-1:0] prev_ff, prev_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [MW-1:0] sprod_ff, sprod_in;
   logic                 full_ff, full_in;
   logic signed [SW-1:0] val_ff, val_in;
   logic signed [SW-1:0] res_sample_ff, res_sample_in;
   logic                 res_note_ff, res_note_in;
   logic signed [SW-1:0] out_sample_ff, out_sample_in;
   logic                 out_note_ff, out_note_in;

   logic                 req_fire;
   logic [CW-1:0]        size_eff;
   logic [AW-1:0]        rd_addr;
   logic                 noise_we;
   logic [SW-1:0]        noise_rdata;
   logic                 work_we;
   logic [AW-1:0]        work_waddr;
   logic signed [SW-1:0] work_wdata;
   logic [SW-1:0]        work_rdata;
   logic                 div_start;
   div_status_type       div_stat;
   logic [DIV_W-1:0]     div_quo;
   logic [DIV_W-1:0]     per_clamp;
   logic                 freq_ok;
   logic signed [SW-1:0] src;
   logic signed [SW:0]   avg_sum;
   logic [DSTEP_W-1:0]   dval;
   logic signed [MW-1:0] rnd;
   logic signed [SW-1:0] scaled;
   logic signed [SW:0]   acc;

   assign req_fire       = req_chan.valid & req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign noise_we = req_fire & (req_chan.req_type == REQ_LOAD)
                   & (32'(req_chan.table_index) < 32'(TABLE_DEPTH));

   always_comb begin
      if (table_size_ff == '0) begin
         size_eff = CW'(1);
      end else if (32'(table_size_ff) > 32'(TABLE_DEPTH)) begin
         size_eff = CW'(TABLE_DEPTH);
      end else begin
         size_eff = CW'(table_size_ff);
      end
   end

   // period length after the zero, table-size and note-end clamps
   always_comb begin
      per_clamp = div_quo;
      if (per_clamp == '0) begin
         per_clamp = DIV_W'(1);
      end
      if (per_clamp > DIV_W'(size_eff)) begin
         per_clamp = DIV_W'(size_eff);
      end
      if ((29'(pos_ff) + 29'(per_clamp)) >= 29'(note_length_ff)) begin
         per_clamp = DIV_W'(note_length_ff) - DIV_W'(pos_ff) - DIV_W'(1);
      end
   end

   assign freq_ok = fvalid_ff & (fv_ff >= FREQ_LOW) & (fv_ff <= FREQ_HIGH);

   always_comb begin
      src     = first_ff ? $signed(noise_rdata) : $signed(work_rdata);
      avg_sum = (SW+1)'(src) + (SW+1)'(prev_ff);
      dval    = (|prod_ff[PROD_W-1:DSTEP_W]) ? '0 : (DSTEP_W'(0) - prod_ff[DSTEP_W-1:0]);
      rnd     = sprod_ff + RND_HALF;
      scaled  = full_ff ? val_ff : rnd[32 +: SW];
      acc     = (SW+1)'(mix_ff) + (SW+1)'(scaled);
   end

   always_comb begin
      state_in       = state_ff;
      sample_rate_in = sample_rate_ff;
      note_length_in = note_length_ff;
      decay_step_in  = decay_step_ff;
      table_size_in  = table_size_ff;
      pos_in         = pos_ff;
      pidx_in        = pidx_ff;
      psamp_in       = psamp_ff;
      hf_in          = hf_ff;
      first_in       = first_ff;
      lat_in         = 1'b0;
      lat_pre_in     = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      mix_in         = mix_ff;
      fv_in          = fv_ff;
      fvalid_in      = fvalid_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      prev_in        = prev_ff;
      prod_in        = prod_ff;
      sprod_in       = sprod_ff;
      full_in        = full_ff;
      val_in         = val_ff;
      res_sample_in  = res_sample_ff;
      res_note_in    = res_note_ff;
      out_sample_in  = out_sample_ff;
      out_note_in    = out_note_ff;
      rd_addr        = AW'(pidx_ff);
      work_we        = 1'b0;
      work_waddr     = AW'(wr_ptr_ff);
      work_wdata     = avg_sum[SW:1];
      div_start      = 1'b0;

      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_SAMPLE_RATE: sample_rate_in = csr_chan.data[RATE_W-1:0];
            CSR_NOTE_LENGTH: note_length_in = csr_chan.data[NLEN_W-1:0];
            CSR_DECAY_STEP:  decay_step_in  = csr_chan.data[DSTEP_W-1:0];
            CSR_TABLE_SIZE:  table_size_in  = csr_chan.data[TSIZE_W-1:0];
            default: ;
         endcase
      end

      if (rsp_chan.valid & rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_chan.req_type == REQ_SAMPLE)) begin
               mix_in    = req_chan.mix_in;
               fv_in     = req_chan.freq_value;
               fvalid_in = req_chan.freq_valid;
               if (req_chan.note_start) begin
                  pos_in   = '0;
                  pidx_in  = '0;
                  psamp_in = '0;
                  hf_in    = FREQ_START;
                  first_in = 1'b1;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((25'(pos_ff) + 25'(1)) >= 25'(note_length_ff)) begin
               res_sample_in = mix_ff;
               res_note_in   = 1'b0;
               state_in      = ST_OUT;
            end else if (pidx_ff >= psamp_ff) begin
               if (freq_ok) begin
                  hf_in = fv_ff;
               end
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               psamp_in = CW'(per_clamp);
               pidx_in  = '0;
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            // the last entry seeds the circular neighbor of entry zero
            rd_addr    = AW'(size_eff - CW'(1));
            rd_ptr_in  = '0;
            wr_ptr_in  = '0;
            lat_in     = 1'b1;
            lat_pre_in = 1'b1;
            state_in   = ST_SWEEP;
         end
         ST_SWEEP: begin
            rd_addr = AW'(rd_ptr_ff);
            if (rd_ptr_ff < size_eff) begin
               rd_ptr_in = rd_ptr_ff + CW'(1);
               lat_in    = 1'b1;
            end
            if (lat_ff) begin
               prev_in = src;
               if (!lat_pre_ff) begin
                  work_we   = 1'b1;
                  wr_ptr_in = wr_ptr_ff + CW'(1);
                  if (wr_ptr_ff == size_eff - CW'(1)) begin
                     first_in = 1'b0;
                     state_in = ST_RD;
                  end
               end
            end
         end
         ST_RD: begin
            rd_addr  = AW'(pidx_ff);
            prod_in  = PROD_W'(pos_ff) * PROD_W'(decay_step_ff);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            val_in   = $signed(work_rdata);
            full_in  = (prod_ff == '0);
            sprod_in = MW'($signed(work_rdata)) * MW'($signed({1'b0, dval}));
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (acc > SAT_MAX) begin
               res_sample_in = SAT_MAX[SW-1:0];
            end else if (acc < SAT_MIN) begin
               res_sample_in = SAT_MIN[SW-1:0];
            end else begin
               res_sample_in = acc[SW-1:0];
            end
            res_note_in = 1'b1;
            pidx_in     = pidx_ff + CW'(1);
            pos_in      = pos_ff + NLEN_W'(1);
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_sample_in = res_sample_ff;
               out_note_in   = res_note_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sample_rate_ff <= RATE_RST;
         note_length_ff <= NLEN_RST;
         decay_step_ff  <= DSTEP_RST;
         table_size_ff  <= TSIZE_RST;
         pos_ff         <= '0;
         pidx_ff        <= '0;
         psamp_ff       <= '0;
         hf_ff          <= FREQ_START;
         first_ff       <= 1'b1;
         lat_ff         <= 1'b0;
         lat_pre_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sample_rate_ff <= sample_rate_in;
         note_length_ff <= note_length_in;
         decay_step_ff  <= decay_step_in;
         table_size_ff  <= table_size_in;
         pos_ff         <= pos_in;
         pidx_ff        <= pidx_in;
         psamp_ff       <= psamp_in;
         hf_ff          <= hf_in;
         first_ff       <= first_in;
         lat_ff         <= lat_in;
         lat_pre_ff     <= lat_pre_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_ff        <= mix_in;
      fv_ff         <= fv_in;
      fvalid_ff     <= fvalid_in;
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      prev_ff       <= prev_in;
      prod_ff       <= prod_in;
      sprod_ff      <= sprod_in;
      full_ff       <= full_in;
      val_ff        <= val_in;
      res_sample_ff <= res_sample_in;
      res_note_ff   <= res_note_in;
      out_sample_ff <= out_sample_in;
      out_note_ff   <= out_note_in;
   end

   pks_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_noise_ram (
      .clock (clock),
      .we    (noise_we),
      .waddr (AW'(req_chan.table_index)),
      .wdata (req_chan.table_value),
      .raddr (rd_addr),
      .rdata (noise_rdata)
   );

   pks_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_work_ram (
      .clock (clock),
      .we    (work_we),
      .waddr (work_waddr),
      .wdata (work_wdata),
      .raddr (rd_addr),
      .rdata (work_rdata)
   );

   pks_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sample_rate_ff, FRAC_W'(0)}),
      .divisor  (hf_in),
      .status   (div_stat),
      .quotient (div_quo)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_sample = out_sample_ff;
   assign rsp_chan.in_note    = out_note_ff;

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_read_in_period: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |-> (pidx_ff < psamp_ff))
      else $error("table read beyond the current period");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (wr_ptr_ff < size_eff))
      else $error("filter sweep write past the table size");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");
`endif
endmodule
